>>> hdl/lhsd_pkg.sv
package lhsd_pkg;

  localparam int COUNT_W = 18;
  localparam int SIZE_W  = 5;
  localparam int BYTE_W  = 8;

  typedef logic [BYTE_W-1:0]  byte_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [SIZE_W-1:0]  size_t;
  typedef logic [15:0]        len16_t;

  localparam count_t COUNT_MAX  = '1;
  localparam int     MIN_IP_LEN = 20;
  localparam logic [3:0] VER_IPV4   = 4'd4;
  localparam logic [3:0] MIN_IHL    = 4'd5;
  localparam size_t  NO_HEADER  = '0;

endpackage

>>> hdl/lhsd_in_if.sv
interface lhsd_in_if;
  import lhsd_pkg::*;

  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input last, output ready);

endinterface

>>> hdl/lhsd_out_if.sv
interface lhsd_out_if;
  import lhsd_pkg::*;

  logic  valid;
  logic  ready;
  size_t header_size;

  modport source (output valid, output header_size, input ready);
  modport sink   (input valid, input header_size, output ready);

endinterface

>>> hdl/lhsd_offset_search.sv
module lhsd_offset_search #(
  parameter int MIN_OFFSET = 14,
  parameter int MAX_OFFSET = 22,
  parameter int WIN_DEPTH  = MAX_OFFSET - MIN_OFFSET + 4
) (
  input  lhsd_pkg::byte_t  win [WIN_DEPTH],
  input  lhsd_pkg::count_t caplen,
  output lhsd_pkg::size_t  found
);
  import lhsd_pkg::*;

  localparam int NUM_OFF = MAX_OFFSET - MIN_OFFSET + 1;

  logic [NUM_OFF-1:0] pass;

  for (genvar k = 0; k < NUM_OFF; k++) begin : g_off
    localparam int OFF = MIN_OFFSET + k;
    byte_t  vi;
    len16_t total;
    len16_t min_total;
    logic   fits;

    assign vi        = win[k];
    assign total     = {win[k+2], win[k+3]};
    assign min_total = {10'd0, vi[3:0], 2'b00};
    assign fits      = caplen >= COUNT_W'(OFF + MIN_IP_LEN);
    // length bound only means anything once the header fits in the capture
    assign pass[k]   = fits && (vi[7:4] == VER_IPV4) && (vi[3:0] >= MIN_IHL) &&
                       (total >= min_total) &&
                       ({2'b00, total} <= caplen - COUNT_W'(OFF));
  end

  // lowest passing offset wins
  always_comb begin
    found = NO_HEADER;
    for (int k = NUM_OFF - 1; k >= 0; k--) begin
      if (pass[k]) begin
        found = SIZE_W'(MIN_OFFSET + k);
      end
    end
  end

endmodule

>>> hdl/link_header_size_detector.sv
// Link header size detector. Packet bytes arrive one per transfer on in_ch, with
// last set on the final byte; one byte is taken every cycle while in_ch.ready is
// high. The bytes at offsets MIN_OFFSET to MAX_OFFSET+3 are held in a register
// window. The transfer of the final byte latches the captured length (byte count,
// saturating at 262143) and marks a check pending; all offsets from MIN_OFFSET
// to MAX_OFFSET are then checked in parallel for a plausible IPv4 header and the
// first match (or 0 when none passes) is loaded into the output register once
// that register is empty or being accepted; header_size is offered from it.
// Input stalls only while that check waits on a full, unaccepted output register.
module link_header_size_detector #(
  parameter int MIN_OFFSET = 14,
  parameter int MAX_OFFSET = 22
) (
  input  logic       clk,
  input  logic       rst_n,
  lhsd_in_if.sink    in_ch,
  lhsd_out_if.source out_ch
);
  import lhsd_pkg::*;

  localparam int WIN_DEPTH = MAX_OFFSET - MIN_OFFSET + 4;
  localparam int IDX_W     = $clog2(WIN_DEPTH);

  count_t count_r, count_nxt;
  count_t count_inc;
  count_t caplen_r;
  count_t rel_pos;
  logic   win_hit;
  byte_t  win_r [WIN_DEPTH];
  logic   eval_valid_r, eval_valid_nxt;
  logic   out_valid_r, out_valid_nxt;
  size_t  out_size_r;
  size_t  found;
  logic   eval_move;
  logic   in_xfer;

  assign eval_move  = eval_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !eval_valid_r || eval_move;
  assign in_xfer    = in_ch.valid && in_ch.ready;

  assign count_inc = (count_r == COUNT_MAX) ? count_r : count_r + count_t'(1);
  assign rel_pos   = count_r - COUNT_W'(MIN_OFFSET);
  assign win_hit   = (count_r >= COUNT_W'(MIN_OFFSET)) &&
                     (rel_pos < COUNT_W'(WIN_DEPTH));

  always_comb begin
    count_nxt = count_r;
    if (in_xfer) begin
      count_nxt = in_ch.last ? '0 : count_inc;
    end
  end

  always_comb begin
    eval_valid_nxt = eval_valid_r;
    if (in_xfer) begin
      eval_valid_nxt = in_ch.last;
    end else if (eval_move) begin
      eval_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (eval_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      eval_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      eval_valid_r <= eval_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers: window, captured length, result
  always_ff @(posedge clk) begin
    if (in_xfer && win_hit) begin
      win_r[rel_pos[IDX_W-1:0]] <= in_ch.data_byte;
    end
    if (in_xfer && in_ch.last) begin
      caplen_r <= count_inc;
    end
    if (eval_move) begin
      out_size_r <= found;
    end
  end

  lhsd_offset_search #(
    .MIN_OFFSET (MIN_OFFSET),
    .MAX_OFFSET (MAX_OFFSET),
    .WIN_DEPTH  (WIN_DEPTH)
  ) u_search (
    .win    (win_r),
    .caplen (caplen_r),
    .found  (found)
  );

  assign out_ch.valid       = out_valid_r;
  assign out_ch.header_size = out_size_r;

endmodule

>>> tb/lhsd_check_pkg.sv
package lhsd_check_pkg;
  import lhsd_pkg::*;

  localparam int MIN_OFFSET = 14;
  localparam int MAX_OFFSET = 22;
  localparam int WIN_SLOTS  = MAX_OFFSET - MIN_OFFSET + 4;

  class header_size_scoreboard;
    count_t byte_cnt;
    byte_t  window [WIN_SLOTS];
    size_t  expected_sizes [$];
    int     mismatches;
    int     sizes_checked;
    int     bytes_taken;
    int     packets_closed;
    int     none_found;

    function new();
      byte_cnt = '0;
      foreach (window[i]) window[i] = '0;
      mismatches     = 0;
      sizes_checked  = 0;
      bytes_taken    = 0;
      packets_closed = 0;
      none_found     = 0;
    endfunction

    // First offset that holds a plausible IPv4 header, or none.
    function size_t find_header_offset(int caplen);
      size_t      found;
      byte_t      vi;
      logic [3:0] ihl;
      len16_t     total;
      found = NO_HEADER;
      for (int off = MAX_OFFSET; off >= MIN_OFFSET; off--) begin
        // walk downward so the lowest passing offset wins
        if (off + MIN_IP_LEN <= caplen) begin
          vi    = window[off - MIN_OFFSET];
          ihl   = vi[3:0];
          total = {window[off - MIN_OFFSET + 2], window[off - MIN_OFFSET + 3]};
          if (vi[7:4] == VER_IPV4 && ihl >= MIN_IHL && int'(total) >= int'(ihl) * 4 &&
              int'(total) <= caplen - off)
            found = size_t'(off);
        end
      end
      return found;
    endfunction

    function void note_byte(byte_t b, logic fin);
      int pos;
      pos = int'(byte_cnt);
      bytes_taken++;
      if (pos >= MIN_OFFSET && pos < MIN_OFFSET + WIN_SLOTS)
        window[pos - MIN_OFFSET] = b;
      if (byte_cnt != COUNT_MAX)
        byte_cnt++;
      if (fin) begin
        expected_sizes.push_back(find_header_offset(int'(byte_cnt)));
        byte_cnt = '0;
        packets_closed++;
      end
    endfunction

    task report_mismatch(string what);
      if (mismatches < 40)
        $display("tb: mismatch at %0t: %s", $time, what);
      mismatches++;
    endtask

    task check_size(size_t got);
      size_t want;
      sizes_checked++;
      if (got == NO_HEADER)
        none_found++;
      if (expected_sizes.size() == 0) begin
        report_mismatch($sformatf("header_size %0d with no packet pending", got));
      end else begin
        want = expected_sizes.pop_front();
        if (got !== want)
          report_mismatch($sformatf("header_size %0d, expected %0d", got, want));
      end
    endtask
  endclass

endpackage

>>> tb/link_header_size_detector_test.sv
module link_header_size_detector_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lhsd_pkg::*;
  import lhsd_check_pkg::*;

  localparam int RANDOM_BYTES   = 700;
  localparam int RANDOM_PACKETS = 12;
  localparam int HOLD_CYCLES    = 400;
  localparam int HOLD_AFTER     = 15;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  lhsd_in_if  in_bus ();
  lhsd_out_if out_bus ();

  link_header_size_detector #(
    .MIN_OFFSET(MIN_OFFSET),
    .MAX_OFFSET(MAX_OFFSET)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_bus.sink),
    .out_ch(out_bus.source)
  );

  header_size_scoreboard sb = new();

  bit    idle_on = 1'b1;
  bit    pressure_done = 1'b0;
  int    hold_left = 0;
  byte_t pkt [$];

  always #5 clk = ~clk;

  initial begin
    in_bus.valid     = 1'b0;
    in_bus.data_byte = '0;
    in_bus.last      = 1'b0;
    out_bus.ready    = 1'b0;
  end

  // Receiver side: random stalls, plus one long hold-off to back the block up.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!pressure_done && sb.sizes_checked >= HOLD_AFTER) begin
        hold_left     = HOLD_CYCLES;
        pressure_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_bus.ready = 1'b0;
        hold_left--;
      end else begin
        out_bus.ready = !(idle_on && $urandom_range(99) < 21);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1)
      sb.check_size(out_bus.header_size);
  end

  task automatic send_byte(byte_t b, logic fin);
    while (idle_on && $urandom_range(99) < 21) begin
      in_bus.valid = 1'b0;
      @(negedge clk);
    end
    in_bus.valid     = 1'b1;
    in_bus.data_byte = b;
    in_bus.last      = fin;
    @(posedge clk);
    while (in_bus.ready !== 1'b1) @(posedge clk);
    sb.note_byte(b, fin);
    @(negedge clk);
  endtask

  task automatic send_packet();
    for (int i = 0; i < pkt.size(); i++)
      send_byte(pkt[i], i == pkt.size() - 1);
  endtask

  task automatic fill_packet(int len, bit random_fill);
    pkt.delete();
    for (int i = 0; i < len; i++)
      pkt.push_back(random_fill ? byte_t'($urandom) : byte_t'(0));
  endtask

  task automatic put_header(int off, byte_t vi, len16_t total);
    pkt[off]     = vi;
    pkt[off + 2] = total[15:8];
    pkt[off + 3] = total[7:0];
  endtask

  task automatic gen_random_packet();
    int         kind;
    int         off;
    int         len;
    int         ihl;
    int         lo;
    int         hi;
    int         total;
    logic [3:0] ver;
    kind = $urandom_range(99);
    if (kind < 15) begin
      fill_packet($urandom_range(1, 33), 1'b1);
    end else if (kind < 25) begin
      fill_packet($urandom_range(34, 64), 1'b1);
    end else begin
      off = $urandom_range(MIN_OFFSET, MAX_OFFSET);
      len = off + MIN_IP_LEN + $urandom_range(0, 24);
      fill_packet(len, 1'b1);
      ihl = ($urandom_range(9) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 15);
      ver = ($urandom_range(9) == 0) ? 4'($urandom) : VER_IPV4;
      lo  = ihl * 4;
      hi  = len - off;
      case ($urandom_range(9))
        0: total = lo - 1;
        1: total = hi + 1;
        2: total = $urandom_range(0, 65535);
        3: total = hi;
        4: total = lo;
        default: total = (lo <= hi) ? $urandom_range(lo, hi) : $urandom_range(0, 65535);
      endcase
      // an earlier near-miss header, laid down first so the real one wins overlaps
      if (off > MIN_OFFSET && $urandom_range(3) == 0)
        put_header($urandom_range(MIN_OFFSET, off - 1), {VER_IPV4, 4'($urandom)},
                   len16_t'($urandom_range(0, 80)));
      put_header(off, {ver, 4'(ihl)}, len16_t'(total));
    end
  endtask

  initial begin
    int rand_bytes;
    int rand_packets;
    rst_n = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // single-byte packet
    fill_packet(1, 1'b0);
    send_packet();
    // header at the lowest offset, one byte too short
    fill_packet(33, 1'b0);
    put_header(MIN_OFFSET, 8'h45, 16'd19);
    send_packet();
    // exact fit at the lowest offset
    fill_packet(34, 1'b0);
    put_header(MIN_OFFSET, 8'h45, 16'd20);
    send_packet();
    // exact fit at the highest offset
    fill_packet(42, 1'b0);
    put_header(MAX_OFFSET, 8'h45, 16'd20);
    send_packet();
    // IHL below minimum
    fill_packet(40, 1'b0);
    put_header(MIN_OFFSET, 8'h44, 16'd20);
    send_packet();
    // wrong version
    fill_packet(40, 1'b0);
    put_header(MIN_OFFSET, 8'h55, 16'd20);
    send_packet();
    // total one past the captured tail
    fill_packet(40, 1'b0);
    put_header(MIN_OFFSET, 8'h45, 16'd27);
    send_packet();
    // total one short of IHL*4
    fill_packet(80, 1'b0);
    put_header(MIN_OFFSET, 8'h4F, 16'd59);
    send_packet();
    // all ones
    pkt.delete();
    repeat (40) pkt.push_back(8'hFF);
    send_packet();
    // first offset fails, a later one passes
    fill_packet(50, 1'b0);
    put_header(MIN_OFFSET, 8'h45, 16'd200);
    put_header(MIN_OFFSET + 2, 8'h46, 16'd24);
    send_packet();
    // a header two bytes up is overwritten by the lower one, which passes
    fill_packet(50, 1'b0);
    put_header(MIN_OFFSET + 2, 8'h45, 16'd30);
    put_header(MIN_OFFSET, 8'h45, 16'd30);
    send_packet();

    rand_bytes   = 0;
    rand_packets = 0;
    while (rand_bytes < RANDOM_BYTES || rand_packets < RANDOM_PACKETS) begin
      idle_on = !(rand_packets >= 8 && rand_packets < 14);
      gen_random_packet();
      send_packet();
      rand_bytes += pkt.size();
      rand_packets++;
    end
    idle_on = 1'b1;
    in_bus.valid = 1'b0;
    in_bus.last  = 1'b0;

    while (sb.expected_sizes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("tb: %0d bytes in %0d packets, corner lengths and headers at offsets %0d to %0d",
             sb.bytes_taken, sb.packets_closed, MIN_OFFSET, MAX_OFFSET);
    $display("tb: %0d header sizes checked, %0d with no header found, one %0d-cycle stall",
             sb.sizes_checked, sb.none_found, HOLD_CYCLES);
    if (sb.mismatches == 0 && sb.expected_sizes.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
